>>> src/bocl_pkg.sv
// ----------------------------------------------------------------------------
// bocl_pkg
// Shared types and constants for the bidirectional occupancy light control.
// ----------------------------------------------------------------------------
package bocl_pkg;

    // Default sizes of the age timers and the occupancy counter
    localparam int AGE_BITS_DEF   = 16;
    localparam int COUNT_BITS_DEF = 8;

    // Fixed field widths
    localparam int OP_W        = 3;
    localparam int LEVEL_W     = 2;
    localparam int LAMP_W      = 3;
    localparam int LIMIT_W     = 8;
    localparam int TICK_W      = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int IN_FIELDS_W = OP_W + 3 + LEVEL_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    // Register reset values
    localparam logic [LIMIT_W-1:0] MEDIUM_LIMIT_RST = 8'd3;
    localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST   = 8'd5;
    localparam logic [TICK_W-1:0]  DEBOUNCE_RST     = 16'd200;
    localparam logic [TICK_W-1:0]  PAIR_WINDOW_RST  = 16'd1200;

    typedef enum logic [OP_W-1:0] {
        OP_TICK           = 3'd0,
        OP_SET_OVERRIDE   = 3'd1,
        OP_CLEAR_OVERRIDE = 3'd2,
        OP_TOGGLE_MOTION  = 3'd3,
        OP_CLEAR_COUNT    = 3'd4,
        OP_TOGGLE_SYSTEM  = 3'd5,
        OP_FULL_RESET     = 3'd6
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MEDIUM_LIMIT = 2'd0,
        CFG_HIGH_LIMIT   = 2'd1,
        CFG_DEBOUNCE     = 2'd2,
        CFG_PAIR_WINDOW  = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        SIDE_NONE  = 2'd0,
        SIDE_OUTER = 2'd1,
        SIDE_INNER = 2'd2
    } side_t;

    // Per-item command from the control stage to the crossing counter
    typedef struct packed {
        logic tick;
        logic clear;
        logic beam_outer;
        logic beam_inner;
    } step_t;

    // Crossing flags for the current item
    typedef struct packed {
        logic entry;
        logic exit;
    } xing_t;

endpackage

>>> src/bocl_crossing.sv
// ----------------------------------------------------------------------------
// bocl_crossing
// Beam debounce, edge pairing and the saturating occupancy counter.
// ----------------------------------------------------------------------------
module bocl_crossing #(
    parameter int AGE_BITS   = bocl_pkg::AGE_BITS_DEF,
    parameter int COUNT_BITS = bocl_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bocl_pkg::step_t               step,
    input  logic [bocl_pkg::TICK_W-1:0]   debounce_ticks,
    input  logic [bocl_pkg::TICK_W-1:0]   pair_window_ticks,
    output logic [COUNT_BITS-1:0]         count_next,
    output bocl_pkg::xing_t               xing
);
    import bocl_pkg::*;

    localparam int CMP_W = (AGE_BITS > TICK_W) ? AGE_BITS : TICK_W;
    localparam logic [AGE_BITS-1:0]   AGE_MAX   = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic                  outer_prev_reg;
    logic                  inner_prev_reg;
    logic [AGE_BITS-1:0]   outer_age_reg;
    logic [AGE_BITS-1:0]   inner_age_reg;
    side_t                 pend_side_reg;
    logic [AGE_BITS-1:0]   pend_age_reg;
    logic [COUNT_BITS-1:0] count_reg;

    logic [AGE_BITS-1:0]   outer_age_inc;
    logic [AGE_BITS-1:0]   inner_age_inc;
    logic [AGE_BITS-1:0]   pend_age_inc;
    logic [CMP_W-1:0]      debounce_x;
    logic [CMP_W-1:0]      window_x;
    logic                  outer_edge;
    logic                  inner_edge;
    side_t                 side_v;
    logic [AGE_BITS-1:0]   pend_age_v;
    logic [COUNT_BITS-1:0] count_v;
    xing_t                 xing_v;

    assign outer_age_inc = (outer_age_reg == AGE_MAX) ? AGE_MAX
                                                      : outer_age_reg + AGE_BITS'(1);
    assign inner_age_inc = (inner_age_reg == AGE_MAX) ? AGE_MAX
                                                      : inner_age_reg + AGE_BITS'(1);
    assign pend_age_inc  = (pend_age_reg == AGE_MAX) ? AGE_MAX
                                                     : pend_age_reg + AGE_BITS'(1);

    assign debounce_x = CMP_W'(debounce_ticks);
    assign window_x   = CMP_W'(pair_window_ticks);

    // falling edge past the debounce age
    assign outer_edge = outer_prev_reg & ~step.beam_outer
                      & (CMP_W'(outer_age_inc) > debounce_x);
    assign inner_edge = inner_prev_reg & ~step.beam_inner
                      & (CMP_W'(inner_age_inc) > debounce_x);

    // Outer edge first, then inner, then drop a stale pending edge
    always_comb
    begin
        side_v     = pend_side_reg;
        pend_age_v = pend_age_inc;
        count_v    = count_reg;
        xing_v     = '0;
        if (outer_edge)
        begin
            if (side_v != SIDE_NONE && CMP_W'(pend_age_v) <= window_x)
            begin
                if (side_v == SIDE_INNER)
                begin
                    if (count_v != '0)
                    begin
                        count_v = count_v - COUNT_BITS'(1);
                    end
                    xing_v.exit = 1'b1;
                end
                side_v = SIDE_NONE;
            end
            else
            begin
                side_v     = SIDE_OUTER;
                pend_age_v = '0;
            end
        end
        if (inner_edge)
        begin
            if (side_v != SIDE_NONE && CMP_W'(pend_age_v) <= window_x)
            begin
                if (side_v == SIDE_OUTER)
                begin
                    if (count_v != COUNT_MAX)
                    begin
                        count_v = count_v + COUNT_BITS'(1);
                    end
                    xing_v.entry = 1'b1;
                end
                side_v = SIDE_NONE;
            end
            else
            begin
                side_v     = SIDE_INNER;
                pend_age_v = '0;
            end
        end
        if (side_v != SIDE_NONE && CMP_W'(pend_age_v) > window_x)
        begin
            side_v = SIDE_NONE;
        end
    end

    assign count_next = step.clear ? '0 : (step.tick ? count_v : count_reg);
    assign xing       = step.tick ? xing_v : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_prev_reg <= 1'b1;
            inner_prev_reg <= 1'b1;
            outer_age_reg  <= AGE_MAX;
            inner_age_reg  <= AGE_MAX;
            pend_side_reg  <= SIDE_NONE;
            pend_age_reg   <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (step.tick)
            begin
                outer_prev_reg <= step.beam_outer;
                inner_prev_reg <= step.beam_inner;
                outer_age_reg  <= outer_edge ? '0 : outer_age_inc;
                inner_age_reg  <= inner_edge ? '0 : inner_age_inc;
                pend_side_reg  <= side_v;
                pend_age_reg   <= pend_age_v;
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> src/bidirectional_occupancy_light_control.sv
// ----------------------------------------------------------------------------
// bidirectional_occupancy_light_control
// Two-beam people counter with light level, lamp drive and command handling.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item is held in the input register, moves to the
//   result register once the output can take it and is then offered on
//   m_axis; a stalled output holds both stages.
// Throughput: one item per cycle while m_axis is not stalled; the whole step is
//   one combinational pass between the input register and the result register.
// Reset: rst_n is asynchronous, active low; it clears the count, pending edge,
//   command flags and both stage valid flags, and loads the register defaults.
module bidirectional_occupancy_light_control #(
    parameter int AGE_BITS   = bocl_pkg::AGE_BITS_DEF,
    parameter int COUNT_BITS = bocl_pkg::COUNT_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Configuration write port
    input  logic                                   cfg_we,
    input  logic [bocl_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [bocl_pkg::CFG_DATA_W-1:0]        cfg_data,
    // Input items
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // op[2:0], beam_outer[3], beam_inner[4], motion_level[5], forced_level[7:6]
    input  logic [bocl_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    // Result items
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // light_level, lamp_bits, head_count, entry_seen, exit_seen,
    // untracked_alert, motion_now; zero-filled to whole bytes
    output logic [((COUNT_BITS + 16) / 8) * 8 - 1:0] m_axis_tdata
);
    import bocl_pkg::*;

    localparam int OUT_FIELDS_W = LEVEL_W + LAMP_W + COUNT_BITS + 4;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int LVL_CMP_W    = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

    // Bit positions of the result fields
    localparam int LAMP_LSB   = LEVEL_W;
    localparam int COUNT_LSB  = LAMP_LSB + LAMP_W;
    localparam int ENTRY_BIT  = COUNT_LSB + COUNT_BITS;
    localparam int EXIT_BIT   = ENTRY_BIT + 1;
    localparam int ALERT_BIT  = ENTRY_BIT + 2;
    localparam int MOTION_BIT = ENTRY_BIT + 3;

    // Thermometer lamp code from a light level
    function automatic logic [LAMP_W-1:0] lamp_code(input logic [LEVEL_W-1:0] level);
        logic [LAMP_W-1:0] code;
        begin
            case (level)
                2'd0:    code = 3'b000;
                2'd1:    code = 3'b001;
                2'd2:    code = 3'b011;
                default: code = 3'b111;
            endcase
            return code;
        end
    endfunction

    // Configuration registers
    logic [LIMIT_W-1:0] medium_limit_reg;
    logic [LIMIT_W-1:0] high_limit_reg;
    logic [TICK_W-1:0]  debounce_reg;
    logic [TICK_W-1:0]  pair_window_reg;

    // Input stage
    logic                  in_valid_reg;
    logic [IN_TDATA_W-1:0] in_data_reg;

    // Result stage
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;

    // Control state
    logic               override_on_reg;
    logic               override_on_next;
    logic [LEVEL_W-1:0] override_level_reg;
    logic [LEVEL_W-1:0] override_level_next;
    logic               motion_off_reg;
    logic               motion_off_next;
    logic               system_off_reg;
    logic               system_off_next;
    logic               motion_prev_reg;

    // Decoded item
    op_t                op;
    logic               beam_outer;
    logic               beam_inner;
    logic               motion_level;
    logic [LEVEL_W-1:0] forced_level;

    logic                  advance;
    logic                  is_tick;
    step_t                 step;
    xing_t                 xing;
    logic [COUNT_BITS-1:0] count_next;
    logic                  motion_now;
    logic                  alert;
    logic [LEVEL_W-1:0]    light_level;
    logic [LAMP_W-1:0]     lamp_bits;
    logic [LVL_CMP_W-1:0]  count_x;

    // ------------------------------------------------------------------
    // Handshake: the input register refills whenever its item moves on
    // to the result register, so a stalled result never starves input
    // for more than the one item already held.
    // ------------------------------------------------------------------
    assign advance       = in_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~in_valid_reg | advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Unpack the held item
    assign op           = op_t'(in_data_reg[OP_W-1:0]);
    assign beam_outer   = in_data_reg[OP_W];
    assign beam_inner   = in_data_reg[OP_W + 1];
    assign motion_level = in_data_reg[OP_W + 2];
    assign forced_level = in_data_reg[OP_W + 4:OP_W + 3];

    assign is_tick = (op == OP_TICK);

    // Command to the crossing counter; it only acts on an advancing item
    assign step.tick       = advance & is_tick;
    assign step.clear      = advance & ((op == OP_CLEAR_COUNT) | (op == OP_FULL_RESET));
    assign step.beam_outer = beam_outer;
    assign step.beam_inner = beam_inner;

    bocl_crossing #(
        .AGE_BITS   (AGE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_crossing (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (step),
        .debounce_ticks    (debounce_reg),
        .pair_window_ticks (pair_window_reg),
        .count_next        (count_next),
        .xing              (xing)
    );

    // ------------------------------------------------------------------
    // Command decode: next values of the control flags. A tick, clear count
    // and the undefined op leave them alone.
    // ------------------------------------------------------------------
    always_comb
    begin
        override_on_next    = override_on_reg;
        override_level_next = override_level_reg;
        motion_off_next     = motion_off_reg;
        system_off_next     = system_off_reg;
        unique case (op)
            OP_SET_OVERRIDE:
            begin
                override_on_next    = 1'b1;
                override_level_next = forced_level;
            end
            OP_CLEAR_OVERRIDE:
            begin
                override_on_next    = 1'b0;
                override_level_next = '0;
            end
            OP_TOGGLE_MOTION:
            begin
                motion_off_next = ~motion_off_reg;
            end
            OP_TOGGLE_SYSTEM:
            begin
                system_off_next = ~system_off_reg;
            end
            OP_FULL_RESET:
            begin
                override_on_next    = 1'b0;
                override_level_next = '0;
                motion_off_next     = 1'b0;
                system_off_next     = 1'b0;
            end
            default:
            begin
                // tick, clear count and the undefined op: flags hold
            end
        endcase
    end

    // Motion after gating: a tick samples the sensor, a command reports the
    // last sample against the updated gate.
    assign motion_now = is_tick ? (~motion_off_reg & motion_level)
                                : (~motion_off_next & motion_prev_reg);

    // Rising motion seen with nobody counted in the room
    assign alert = is_tick & ~motion_prev_reg & motion_now & (count_next == '0);

    // Light level: override, then system off, then motion at zero count,
    // then the two count thresholds.
    assign count_x = LVL_CMP_W'(count_next);

    always_comb
    begin
        if (override_on_next)
        begin
            light_level = override_level_next;
        end
        else if (system_off_next)
        begin
            light_level = 2'd0;
        end
        else if (count_next == '0)
        begin
            light_level = {1'b0, motion_now};
        end
        else if (count_x <= LVL_CMP_W'(medium_limit_reg))
        begin
            light_level = 2'd1;
        end
        else if (count_x <= LVL_CMP_W'(high_limit_reg))
        begin
            light_level = 2'd2;
        end
        else
        begin
            light_level = 2'd3;
        end
    end

    // Lamps go dark whenever the system is off, override or not
    assign lamp_bits = system_off_next ? '0 : lamp_code(light_level);

    assign out_data_next = OUT_TDATA_W'({motion_now, alert, xing.exit, xing.entry,
                                         count_next, lamp_bits, light_level});

    // ------------------------------------------------------------------
    // Configuration registers: user writes only while block is idle; unenforced
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            medium_limit_reg <= MEDIUM_LIMIT_RST;
            high_limit_reg   <= HIGH_LIMIT_RST;
            debounce_reg     <= DEBOUNCE_RST;
            pair_window_reg  <= PAIR_WINDOW_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MEDIUM_LIMIT: medium_limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_HIGH_LIMIT:   high_limit_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_DEBOUNCE:     debounce_reg     <= cfg_data[TICK_W-1:0];
                CFG_PAIR_WINDOW:  pair_window_reg  <= cfg_data[TICK_W-1:0];
                default:          medium_limit_reg <= medium_limit_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control and control flags
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            override_on_reg    <= 1'b0;
            override_level_reg <= '0;
            motion_off_reg     <= 1'b0;
            system_off_reg     <= 1'b0;
            motion_prev_reg    <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg      <= 1'b1;
                override_on_reg    <= override_on_next;
                override_level_reg <= override_level_next;
                motion_off_reg     <= motion_off_next;
                system_off_reg     <= system_off_next;
                if (is_tick)
                begin
                    motion_prev_reg <= motion_now;
                end
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: load on accept / advance, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    // An outer edge that closes an exit clears the pending side, so one
    // tick can never close both crossings.
    a_one_crossing: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[ENTRY_BIT] && m_axis_tdata[EXIT_BIT]))
        else $error("entry and exit in the same result");

    // Lamp drive is always a thermometer code
    a_lamp_thermo: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[COUNT_LSB-1:LAMP_LSB] == 3'b000 ||
                           m_axis_tdata[COUNT_LSB-1:LAMP_LSB] == 3'b001 ||
                           m_axis_tdata[COUNT_LSB-1:LAMP_LSB] == 3'b011 ||
                           m_axis_tdata[COUNT_LSB-1:LAMP_LSB] == 3'b111))
        else $error("lamp bits not a thermometer code");

    // An alert needs gated motion and an empty room
    a_alert_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[ALERT_BIT]) |->
            (m_axis_tdata[MOTION_BIT] && m_axis_tdata[ENTRY_BIT-1:COUNT_LSB] == '0))
        else $error("alert without motion at zero count");

    // A held item never vanishes while the result side is stalled
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_axis_tready) |=> in_valid_reg)
        else $error("input item dropped during stall");
`endif

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-beam occupancy counter and light control.
// A clocked driver feeds beam samples and commands from a queue, a clocked
// monitor predicts the light result of every accepted item and compares it
// field by field with the result items that come back. The run moves through
// a short directed sequence, two random phases with opposite stall mixes and
// a stall-free phase that climbs the count to its ceiling, with the limits,
// debounce and pairing window taken to their extremes between phases.
// ----------------------------------------------------------------------------
module testbench;
    import bocl_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 12;
    localparam int RES_W         = ((COUNT_BITS_DEF + 16) / 8) * 8;
    localparam int STALL_LIMIT   = 4000;  // cycles with no item moving on either side
    localparam int SETTLE_CYCLES = 4;     // two-stage pipe plus margin
    localparam int GAP_CAP       = 16;    // gap bound; longest gap is GAP_CAP + 2
    localparam int REARM_CAP     = 6;     // rest bound; longest rest is REARM_CAP + 1

    localparam logic [OP_W-1:0]    OP_UNDEFINED = 3'd7;
    localparam logic [TICK_W-1:0]  AGE_SAT      = '1;
    localparam logic [7:0]         COUNT_CEIL   = 8'hFF;

    localparam logic [LEVEL_W-1:0] LEVEL_OFF  = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_MED  = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 2'd3;

    // One result item, last field in the lowest bits
    typedef struct packed {
        logic               motion_now;
        logic               untracked_alert;
        logic               exit_seen;
        logic               entry_seen;
        logic [7:0]         head_count;
        logic [LAMP_W-1:0]  lamp_bits;
        logic [LEVEL_W-1:0] light_level;
    } light_result_t;

    // One pending input item; wait_drain holds it back until the pipe is empty
    typedef struct {
        logic [IN_TDATA_W-1:0] word;
        bit                    wait_drain;
    } sample_t;

    // ------------------------------------------------------------------------
    // DUT signals; those the bench drives are known from time zero
    // ------------------------------------------------------------------------
    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // op[2:0], beam_outer[3], beam_inner[4], motion_level[5], forced_level[7:6]
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // light_level[1:0], lamp_bits[4:2], head_count[12:5], entry_seen[13],
    // exit_seen[14], untracked_alert[15], motion_now[16], zeros above
    logic [RES_W-1:0]       m_axis_tdata;

    bidirectional_occupancy_light_control i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    sample_t       pending_samples[$];    // filled by the sequence, drained by the driver
    light_result_t light_results_due[$];  // predicted results, oldest first
    int            n_queued      = 0;
    int            n_sent        = 0;     // items accepted by the block (driver side)
    int            n_checked     = 0;     // result items taken (monitor side)
    int            mismatches    = 0;
    int            stall_cycles  = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;

    // Predictor copy of the block state and registers
    logic               beam_o_last, beam_i_last, motion_last;
    logic [TICK_W-1:0]  age_o, age_i, wait_age;
    side_t              wait_side;
    logic [7:0]         people;
    logic               ovr_on;
    logic [LEVEL_W-1:0] ovr_level;
    logic               motion_off, sys_off;
    logic [LIMIT_W-1:0] lim_med, lim_high;
    logic [TICK_W-1:0]  deb_ticks, win_ticks;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    task automatic reset_occupancy();
        beam_o_last = 1'b1;
        beam_i_last = 1'b1;
        motion_last = 1'b0;
        age_o       = AGE_SAT;
        age_i       = AGE_SAT;
        wait_side   = SIDE_NONE;
        wait_age    = '0;
        people      = '0;
        ovr_on      = 1'b0;
        ovr_level   = LEVEL_OFF;
        motion_off  = 1'b0;
        sys_off     = 1'b0;
        lim_med     = MEDIUM_LIMIT_RST;
        lim_high    = HIGH_LIMIT_RST;
        deb_ticks   = DEBOUNCE_RST;
        win_ticks   = PAIR_WINDOW_RST;
    endtask

    function automatic logic [TICK_W-1:0] age_up(input logic [TICK_W-1:0] a);
        return (a == AGE_SAT) ? a : a + 1'b1;
    endfunction

    // Pair a counted beam edge with the waiting one, or make it the waiting one.
    // An edge on the waiting side within the window just drops the waiting edge.
    function automatic void pair_edge(input side_t side, inout logic ent, inout logic ext);
        if (wait_side != SIDE_NONE && wait_age <= win_ticks) begin
            if (wait_side == SIDE_OUTER && side == SIDE_INNER) begin
                if (people != COUNT_CEIL)
                    people = people + 1'b1;
                ent = 1'b1;
            end
            else if (wait_side == SIDE_INNER && side == SIDE_OUTER) begin
                if (people != '0)
                    people = people - 1'b1;
                ext = 1'b1;
            end
            wait_side = SIDE_NONE;
        end
        else begin
            wait_side = side;
            wait_age  = '0;
        end
    endfunction

    function automatic light_result_t step_occupancy(input logic [IN_TDATA_W-1:0] word);
        logic [OP_W-1:0]    op;
        logic               bo, bi, ml;
        logic [LEVEL_W-1:0] fl;
        logic               ent, ext, alert, motion;
        logic [LEVEL_W-1:0] level;
        light_result_t      r;
        op     = word[2:0];
        bo     = word[3];
        bi     = word[4];
        ml     = word[5];
        fl     = word[7:6];
        ent    = 1'b0;
        ext    = 1'b0;
        alert  = 1'b0;
        motion = 1'b0;
        case (op)
            OP_TICK: begin
                age_o    = age_up(age_o);
                age_i    = age_up(age_i);
                wait_age = age_up(wait_age);
                motion   = motion_off ? 1'b0 : ml;
                // Outer first, so both beams in one tick pair as an entry
                if (beam_o_last && !bo && age_o > deb_ticks) begin
                    age_o = '0;
                    pair_edge(SIDE_OUTER, ent, ext);
                end
                if (beam_i_last && !bi && age_i > deb_ticks) begin
                    age_i = '0;
                    pair_edge(SIDE_INNER, ent, ext);
                end
                if (!motion_last && motion && people == '0)
                    alert = 1'b1;
                // Drop a waiting edge once it has outlived the window
                if (wait_side != SIDE_NONE && wait_age > win_ticks)
                    wait_side = SIDE_NONE;
                beam_o_last = bo;
                beam_i_last = bi;
                motion_last = motion;
            end
            OP_SET_OVERRIDE: begin
                ovr_on    = 1'b1;
                ovr_level = fl;
            end
            OP_CLEAR_OVERRIDE: begin
                ovr_on    = 1'b0;
                ovr_level = LEVEL_OFF;
            end
            OP_TOGGLE_MOTION: motion_off = ~motion_off;
            OP_CLEAR_COUNT:   people = '0;
            OP_TOGGLE_SYSTEM: sys_off = ~sys_off;
            OP_FULL_RESET: begin
                people     = '0;
                ovr_on     = 1'b0;
                ovr_level  = LEVEL_OFF;
                motion_off = 1'b0;
                sys_off    = 1'b0;
            end
            default: ;  // undefined op changes nothing
        endcase
        // Commands report the held motion level through the updated gate
        if (op != OP_TICK)
            motion = motion_off ? 1'b0 : motion_last;

        if (ovr_on)
            level = ovr_level;
        else if (sys_off)
            level = LEVEL_OFF;
        else if (people == '0)
            level = motion ? LEVEL_LOW : LEVEL_OFF;
        else if (people <= lim_med)
            level = LEVEL_LOW;
        else if (people <= lim_high)
            level = LEVEL_MED;
        else
            level = LEVEL_HIGH;

        r.light_level     = level;
        r.lamp_bits       = sys_off ? '0 : {level >= LEVEL_HIGH, level >= LEVEL_MED,
                                            level >= LEVEL_LOW};
        r.head_count      = people;
        r.entry_seen      = ent;
        r.exit_seen       = ext;
        r.untracked_alert = alert;
        r.motion_now      = motion;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Driver: present the next pending item, hold it until taken
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        sample_t nxt;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                n_sent <= n_sent + 1;
            // The bus may only change once the current item is taken
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_samples.size() != 0
                    && !(pending_samples[0].wait_drain && (s_axis_tvalid || n_sent != n_checked))
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_samples.pop_front();
                    s_axis_tdata  <= nxt.word;
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result side back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: check taken results, then predict for items taken this edge
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        light_result_t want, got;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                n_checked <= n_checked + 1;
                got = light_result_t'(m_axis_tdata[$bits(light_result_t)-1:0]);
                if (light_results_due.size() == 0)
                begin
                    $error("result item with nothing predicted: %h", m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = light_results_due.pop_front();
                    check_field("light_level", want.light_level, got.light_level);
                    check_field("lamp_bits", want.lamp_bits, got.lamp_bits);
                    check_field("head_count", want.head_count, got.head_count);
                    check_field("entry_seen", want.entry_seen, got.entry_seen);
                    check_field("exit_seen", want.exit_seen, got.exit_seen);
                    check_field("untracked_alert", want.untracked_alert, got.untracked_alert);
                    check_field("motion_now", want.motion_now, got.motion_now);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                light_results_due.push_back(step_occupancy(s_axis_tdata));
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if nothing moves for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("[bidirectional_occupancy_light_control] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence helpers
    // ------------------------------------------------------------------------
    function automatic logic rnd_bit();
        return 1'($urandom_range(1));
    endfunction

    function automatic void push_sample(input logic [OP_W-1:0] op, input logic bo, bi, ml,
                                        input logic [LEVEL_W-1:0] fl, input bit hold = 1'b0);
        sample_t s;
        s.word       = {fl, ml, bi, bo, op};
        s.wait_drain = hold;
        pending_samples.push_back(s);
        n_queued++;
    endfunction

    // Random-content tick with fixed beam levels
    function automatic void push_tick(input logic bo, bi, input bit hold = 1'b0);
        push_sample(OP_TICK, bo, bi, rnd_bit(), 2'($urandom_range(3)), hold);
    endfunction

    // One crossing: first beam falls, an optional gap with rare chatter on the
    // first beam, the second beam falls, then both rest to re-arm the debounce
    function automatic void push_crossing(input bit entering, input bit hold);
        int gap_max, gap, rest;
        logic chatter;
        gap_max = (win_ticks > GAP_CAP) ? GAP_CAP + 2 : int'(win_ticks) + 2;
        gap     = $urandom_range(gap_max);
        rest    = (deb_ticks > REARM_CAP) ? REARM_CAP + 1 : int'(deb_ticks) + 1;
        if (entering)
            push_tick(1'b0, 1'b1, hold);
        else
            push_tick(1'b1, 1'b0, hold);
        repeat (gap)
        begin
            chatter = ($urandom_range(4) == 0);
            if (entering)
                push_tick(chatter, 1'b1);
            else
                push_tick(1'b1, chatter);
        end
        if (entering)
            push_tick(rnd_bit(), 1'b0);
        else
            push_tick(1'b0, rnd_bit());
        repeat (rest)
            push_tick(1'b1, 1'b1);
    endfunction

    // Mostly well-formed crossings, some commands, some raw noise
    function automatic void push_random_mix(input int count);
        int target, pick;
        bit hold;
        target = n_queued + count;
        while (n_queued < target)
        begin
            pick = $urandom_range(99);
            hold = ($urandom_range(49) == 0);
            if (pick < 65)
                push_crossing($urandom_range(99) < 65, hold);
            else if (pick < 80)
                push_sample(3'($urandom_range(1, 7)), rnd_bit(), rnd_bit(), rnd_bit(),
                            2'($urandom_range(3)), hold);
            else
                push_sample(OP_TICK, rnd_bit(), rnd_bit(), rnd_bit(),
                            2'($urandom_range(3)), hold);
        end
    endfunction

    // Write one register on the port and mirror it in the predictor
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_MEDIUM_LIMIT: lim_med   = value[LIMIT_W-1:0];
            CFG_HIGH_LIMIT:   lim_high  = value[LIMIT_W-1:0];
            CFG_DEBOUNCE:     deb_ticks = value;
            CFG_PAIR_WINDOW:  win_ticks = value;
            default: ;
        endcase
    endtask

    task automatic write_all_regs(input logic [LIMIT_W-1:0] med, high,
                                  input logic [TICK_W-1:0] deb, win);
        write_reg(CFG_MEDIUM_LIMIT, CFG_DATA_W'(med));
        write_reg(CFG_HIGH_LIMIT, CFG_DATA_W'(high));
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_PAIR_WINDOW, win);
        @(negedge clk);
    endtask

    // Wait until every queued item is taken and every result checked
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || s_axis_tvalid || n_sent != n_checked);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        reset_occupancy();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Phase A: sender mostly busy, receiver mostly stalled
        send_idle_pct = 19;
        recv_idle_pct = 79;

        // Directed: short debounce and window so crossings stay brief
        write_all_regs(8'd1, 8'd2, 16'd1, 16'd4);
        push_tick(1'b1, 1'b0);                              // inner waits
        push_tick(1'b0, 1'b1);                              // exit at zero count
        push_tick(1'b1, 1'b1);
        push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b1);                              // outer waits
        push_tick(1'b0, 1'b0);                              // entry
        push_tick(1'b1, 1'b1);
        push_tick(1'b1, 1'b1);
        push_sample(OP_TICK, 1'b0, 1'b0, 1'b1, 2'd3);       // both beams, one tick
        push_tick(1'b1, 1'b1);
        push_tick(1'b1, 1'b1);
        push_tick(1'b1, 1'b0);                              // inner waits
        push_tick(1'b1, 1'b1);
        push_tick(1'b1, 1'b1);
        push_tick(1'b1, 1'b0);                              // same side again
        push_sample(OP_SET_OVERRIDE, 1'b1, 1'b1, 1'b1, 2'd3);
        push_sample(OP_SET_OVERRIDE, 1'b0, 1'b0, 1'b0, 2'd0);
        push_sample(OP_CLEAR_OVERRIDE, 1'b0, 1'b0, 1'b0, 2'd2);
        push_sample(OP_TOGGLE_MOTION, 1'b0, 1'b0, 1'b0, 2'd0);
        push_sample(OP_TICK, 1'b1, 1'b1, 1'b1, 2'd1);       // motion gated off
        push_sample(OP_TOGGLE_MOTION, 1'b0, 1'b0, 1'b0, 2'd0);
        push_sample(OP_CLEAR_COUNT, 1'b0, 1'b0, 1'b0, 2'd0);
        push_sample(OP_TICK, 1'b1, 1'b1, 1'b1, 2'd0);       // motion at zero count
        push_sample(OP_TOGGLE_SYSTEM, 1'b0, 1'b0, 1'b0, 2'd0);
        push_sample(OP_TICK, 1'b1, 1'b1, 1'b0, 2'd0);
        push_sample(OP_FULL_RESET, 1'b0, 1'b0, 1'b0, 2'd0);
        push_sample(OP_UNDEFINED, 1'b1, 1'b1, 1'b1, 2'd3);
        wait_drained();

        // Random crossings with small limits and a short window
        write_all_regs(8'($urandom_range(3)), 8'($urandom_range(2, 8)),
                       16'($urandom_range(4)), 16'($urandom_range(1, 12)));
        push_random_mix(200);
        wait_drained();

        // Phase B: swap the stall mix, widest window, lowest medium limit
        send_idle_pct = 79;
        recv_idle_pct = 19;
        write_all_regs(8'd0, 8'($urandom_range(1, 4)), 16'd1, 16'hFFFF);
        push_random_mix(200);
        wait_drained();

        // Phase C: no stalls; climb to the count ceiling with zero debounce and
        // zero window, so only both beams in one tick pair up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_all_regs(8'd0, 8'hFF, 16'd0, 16'd0);
        push_sample(OP_FULL_RESET, 1'b1, 1'b1, 1'b0, 2'd0);
        repeat (258)
        begin
            push_tick(1'b0, 1'b0);
            push_tick(1'b1, 1'b1);
        end
        wait_drained();

        // Debounce at its maximum: no edge may count any more
        write_all_regs(8'hFF, 8'd0, 16'hFFFF, 16'hFFFF);
        push_random_mix(30);
        wait_drained();

        $display("Ran %0d items: directed crossings and commands, random crossings under",
                 n_sent);
        $display("two stall mixes, a climb to the count ceiling, limits and timers at extremes");
        if (mismatches == 0 && light_results_due.size() == 0)
            $display("[bidirectional_occupancy_light_control] OK");
        else
        begin
            if (light_results_due.size() != 0)
                $error("%0d predicted results never arrived", light_results_due.size());
            $display("[bidirectional_occupancy_light_control] ERROR");
        end
        $finish;
    end

endmodule

>>> bidirectional_occupancy_light_control.f
src/bocl_pkg.sv
src/bocl_crossing.sv
src/bidirectional_occupancy_light_control.sv
sim/testbench.sv
